FILE: rtl/core/fdt_pkg.sv
// Shared types and constants for the four-channel down timer register block.
// Used by fdt_channel and four_channel_down_timer_regs_top; no dependencies.
`timescale 1ns / 1ps

package fdt_pkg;

    // Default geometry
    localparam int NUM_TIMERS_DEF  = 4;
    localparam int COUNT_WIDTH_DEF = 32;

    // Beat field widths
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 10;
    localparam int DATA_W  = 32;
    localparam int IRQ_W   = 4;
    localparam int CTRL_W  = 4;
    localparam int S_DATA_W = 48;   // word_address + write_data, padded to bytes
    localparam int M_DATA_W = 40;   // read_data + irq_lines, padded to bytes

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Word address split: block = word / 5, register = word % 5
    localparam int WORDS_PER_TIMER = 5;
    localparam int DIV5_MUL   = 205;           // exact for words below 1024
    localparam int DIV5_SHIFT = 10;
    localparam int PROD_W     = ADDR_W + 8;
    localparam int BLK_W      = PROD_W - DIV5_SHIFT;
    localparam int REG_W      = 3;

    localparam logic [BLK_W-1:0] SYS_BLOCK = 8'd8;

    // Per-timer register codes
    localparam logic [REG_W-1:0] REG_LOAD  = 3'd0;
    localparam logic [REG_W-1:0] REG_COUNT = 3'd1;
    localparam logic [REG_W-1:0] REG_CTRL  = 3'd2;
    localparam logic [REG_W-1:0] REG_EOI   = 3'd3;
    localparam logic [REG_W-1:0] REG_STAT  = 3'd4;

    // System block register codes
    localparam logic [REG_W-1:0] SYS_MSTAT = 3'd0;
    localparam logic [REG_W-1:0] SYS_CLR   = 3'd1;
    localparam logic [REG_W-1:0] SYS_RAW   = 3'd2;

    // Control bit positions
    localparam int CTL_ENABLE_BIT = 0;
    localparam int CTL_MASK_BIT   = 2;

    // Per-channel command for one processed item
    typedef struct packed {
        logic tick;
        logic wr_load;
        logic wr_ctrl;
        logic clr_flag;
    } chan_cmd_t;

endpackage

FILE: rtl/core/fdt_channel.sv
// One down-counter channel: load value, control bits, count and raw flag.
// Depends on fdt_pkg for the command struct and control bit positions.
`timescale 1ns / 1ps

module fdt_channel #(
    parameter int COUNT_WIDTH = fdt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdt_pkg::chan_cmd_t            cmd,
    input  logic [fdt_pkg::DATA_W-1:0]    wdata,
    output logic [COUNT_WIDTH-1:0]        load_value,
    output logic [COUNT_WIDTH-1:0]        count,
    output logic [fdt_pkg::CTRL_W-1:0]    ctrl,
    output logic                          flag,
    output logic                          line,
    output logic                          line_next
);

    logic [COUNT_WIDTH-1:0]     load_reg,  load_next;
    logic [COUNT_WIDTH-1:0]     count_reg, count_next;
    logic [fdt_pkg::CTRL_W-1:0] ctrl_reg,  ctrl_next;
    logic                       flag_reg,  flag_next;

    // Apply the one command of this item
    always_comb
    begin
        load_next  = load_reg;
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        flag_next  = flag_reg;
        if (cmd.tick && ctrl_reg[fdt_pkg::CTL_ENABLE_BIT] && (load_reg != '0))
        begin
            if (count_reg <= COUNT_WIDTH'(1))
            begin
                flag_next  = 1'b1;
                count_next = load_reg;
            end
            else
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        if (cmd.wr_load)
        begin
            load_next = wdata[COUNT_WIDTH-1:0];
        end
        if (cmd.wr_ctrl)
        begin
            ctrl_next = wdata[fdt_pkg::CTRL_W-1:0];
            if (wdata[fdt_pkg::CTL_ENABLE_BIT])
            begin
                count_next = load_reg;
            end
        end
        if (cmd.clr_flag)
        begin
            flag_next = 1'b0;
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= '0;
            count_reg <= '0;
            ctrl_reg  <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            load_reg  <= load_next;
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
            flag_reg  <= flag_next;
        end
    end

    assign load_value = load_reg;
    assign count      = count_reg;
    assign ctrl       = ctrl_reg;
    assign flag       = flag_reg;
    assign line       = flag_reg & ~ctrl_reg[fdt_pkg::CTL_MASK_BIT];
    assign line_next  = flag_next & ~ctrl_next[fdt_pkg::CTL_MASK_BIT];

endmodule

FILE: rtl/core/four_channel_down_timer_regs_top.sv
// Pipeline: a beat accepted into the input register is processed into the result register
// once that stage is free or being drained, and its result beat is presented from there.
// Throughput: one beat per cycle unless m_axis_tready stalls; ticks and register accesses
// interleave freely, set by the input and result registers around decode and update logic.
// Reset (rst_n low, asynchronous): clears both stage valids and all timer state to zero.
// Top level of the down timer block; depends on fdt_pkg and fdt_channel.
`timescale 1ns / 1ps

module four_channel_down_timer_regs_top #(
    parameter int NUM_TIMERS  = fdt_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = fdt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [9:0] word_address, [41:10] write_data, [47:42] zero
    input  logic [fdt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [fdt_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] read_data, [35:32] irq_lines, [39:36] zero
    output logic [fdt_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int AW = fdt_pkg::ADDR_W;
    localparam int DW = fdt_pkg::DATA_W;

    // Input stage
    logic                          in_valid_reg;
    logic [fdt_pkg::KIND_W-1:0]    in_kind_reg;
    logic [AW-1:0]                 in_word_reg;
    logic [DW-1:0]                 in_wdata_reg;

    // Result stage
    logic                          out_valid_reg;
    logic [DW-1:0]                 out_rdata_reg, out_rdata_next;
    logic [fdt_pkg::IRQ_W-1:0]     out_irq_reg,   out_irq_next;

    logic proc;
    logic s_fire;

    // Advance when the result stage is free or being drained
    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Split word address into block and register (multiply by reciprocal of 5)
    logic [fdt_pkg::PROD_W-1:0] div_prod;
    logic [fdt_pkg::BLK_W-1:0]  blk;
    logic [AW-1:0]              blk_x5;
    logic [fdt_pkg::REG_W-1:0]  reg_sel;

    assign div_prod = fdt_pkg::PROD_W'(in_word_reg)
                    * fdt_pkg::PROD_W'(fdt_pkg::DIV5_MUL);
    assign blk      = div_prod[fdt_pkg::PROD_W-1:fdt_pkg::DIV5_SHIFT];
    assign blk_x5   = AW'(blk) * AW'(fdt_pkg::WORDS_PER_TIMER);
    assign reg_sel  = fdt_pkg::REG_W'(in_word_reg - blk_x5);

    logic is_tick, is_read, is_write, is_sys;
    assign is_tick  = proc && (in_kind_reg == fdt_pkg::KIND_TICK);
    assign is_read  = proc && (in_kind_reg == fdt_pkg::KIND_READ);
    assign is_write = proc && (in_kind_reg == fdt_pkg::KIND_WRITE);
    assign is_sys   = (blk == fdt_pkg::SYS_BLOCK);

    // Channels
    logic [NUM_TIMERS-1:0] flag_vec;
    logic [NUM_TIMERS-1:0] line_vec;
    logic [NUM_TIMERS-1:0] line_next_vec;
    logic [DW-1:0]         chan_rd [NUM_TIMERS];

    for (genvar t = 0; t < NUM_TIMERS; t++)
    begin : g_chan
        fdt_pkg::chan_cmd_t            cmd;
        logic                          hit;
        logic [COUNT_WIDTH-1:0]        load_value;
        logic [COUNT_WIDTH-1:0]        count;
        logic [fdt_pkg::CTRL_W-1:0]    ctrl;

        assign hit          = (blk == fdt_pkg::BLK_W'(t));
        assign cmd.tick     = is_tick;
        assign cmd.wr_load  = is_write && hit && (reg_sel == fdt_pkg::REG_LOAD);
        assign cmd.wr_ctrl  = is_write && hit && (reg_sel == fdt_pkg::REG_CTRL);
        assign cmd.clr_flag = is_read
                           && ((hit && (reg_sel == fdt_pkg::REG_EOI))
                            || (is_sys && (reg_sel == fdt_pkg::SYS_CLR)));

        fdt_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .wdata      (in_wdata_reg),
            .load_value (load_value),
            .count      (count),
            .ctrl       (ctrl),
            .flag       (flag_vec[t]),
            .line       (line_vec[t]),
            .line_next  (line_next_vec[t])
        );

        // Per-channel register read
        always_comb
        begin
            chan_rd[t] = '0;
            if (hit)
            begin
                unique case (reg_sel)
                    fdt_pkg::REG_LOAD:  chan_rd[t] = DW'(load_value);
                    fdt_pkg::REG_COUNT: chan_rd[t] = DW'(count);
                    fdt_pkg::REG_CTRL:  chan_rd[t] = DW'(ctrl);
                    fdt_pkg::REG_STAT:  chan_rd[t] = DW'(line_vec[t]);
                    default:            chan_rd[t] = '0;
                endcase
            end
        end
    end

    // Select read data and next interrupt lines
    logic [DW-1:0] rd_val;
    logic [DW-1:0] line_next_wide;

    always_comb
    begin
        rd_val = '0;
        if (is_sys)
        begin
            unique case (reg_sel)
                fdt_pkg::SYS_MSTAT: rd_val = DW'(line_vec);
                fdt_pkg::SYS_RAW:   rd_val = DW'(flag_vec);
                default:            rd_val = '0;
            endcase
        end
        else
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                rd_val = rd_val | chan_rd[t];
            end
        end
        line_next_wide = DW'(line_next_vec);
        out_rdata_next = (in_kind_reg == fdt_pkg::KIND_READ) ? rd_val : '0;
        out_irq_next   = line_next_wide[fdt_pkg::IRQ_W-1:0];
    end

    // Hold stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture beat payloads
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_kind_reg  <= s_axis_tuser;
            in_word_reg  <= s_axis_tdata[AW-1:0];
            in_wdata_reg <= s_axis_tdata[AW+DW-1:AW];
        end
        if (proc)
        begin
            out_rdata_reg <= out_rdata_next;
            out_irq_reg   <= out_irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fdt_pkg::M_DATA_W-DW-fdt_pkg::IRQ_W){1'b0}},
                            out_irq_reg, out_rdata_reg};

endmodule
